FILE: rtl/ctl_pkg.sv
// Shared types, constants and helpers for the chunk tag locator.
// Used by the locator top level and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctl_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LOC_BITS    = 32;
   localparam int TAG_BITS    = 32;
   localparam int SIZE_BITS   = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
   localparam logic [OFFSET_BITS-1:0] HDR_BACK = OFFSET_BITS'(3);

   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_Z   = 8'h5A;
   localparam logic [7:0] CHAR_TWO = 8'h32;
   localparam logic [7:0] CHAR_M   = 8'h4D;

   localparam logic [1:0] WINDOW_FULL = 2'd3;
   localparam logic [1:0] SIZE_LAST   = 2'd3;

   // register select on address bit 2
   localparam logic CSR_TARGET_TAG   = 1'b0;
   localparam logic CSR_START_OFFSET = 1'b1;

   typedef enum logic [1:0] {
      MODE_SKIP = 2'd0,
      MODE_SCAN = 2'd1,
      MODE_SIZE = 2'd2,
      MODE_DONE = 2'd3
   } mode_type;

   function automatic logic tag_char_ok(input logic [7:0] c);
      tag_char_ok = ((c >= CHAR_A) && (c <= CHAR_Z)) || (c == CHAR_TWO);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/chunk_tag_locator.sv
// Chunk tag locator: byte-stream chunk walker with an APB register port.
// Depends on ctl_pkg for widths, parse modes and tag character checks.
//
// Feed a file one byte per transfer on req_ with tlast on its final byte. Bytes
// before start_offset are dropped; the block then slides a 4-byte window looking
// for a chunk header (three bytes A-Z or '2', then 'M'). A header equal to
// target_tag yields one result with found set and the header's byte offset; any
// other header has its little-endian size read and that many bytes skipped. A file
// that ends without a match yields one result with found clear and location 0.
// After a result, bytes up to tlast are dropped and the block rearms for the next
// file. One byte is taken per clock while the result is not stalled: each byte
// passes an input register, the compare, shift and counter logic, and a result
// register. A stalled result holds back only bytes that follow.
// Write registers only while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none

module chunk_tag_locator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: [7:0] data_byte
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: [31:0] location
   output logic [ctl_pkg::LOC_BITS-1:0]           rsp_tdata,
   // tuser: [0] found
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ctl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [ctl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ctl_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import ctl_pkg::*;

   logic [TAG_BITS-1:0]    target_ff, target_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_found_ff, out_found_in;
   logic [LOC_BITS-1:0]    out_loc_ff, out_loc_in;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [23:0]            recent_ff, recent_in;
   logic [1:0]             count_ff, count_in;
   logic [SIZE_BITS-1:0]   acc_ff, acc_in;
   logic [1:0]             idx_ff, idx_in;
   logic [OFFSET_BITS-1:0] skip_ff, skip_in;

   logic       csr_write;
   logic       out_free;
   logic       process;
   mode_type   mode_eff;
   logic [23:0] recent_eff;
   logic [1:0]  count_eff;
   logic [31:0] window;
   logic        hit;
   logic        match;
   logic [SIZE_BITS-1:0] acc_next;
   logic [OFFSET_BITS-1:0] hdr_pos;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         CSR_TARGET_TAG:   csr_prdata = target_ff;
         CSR_START_OFFSET: csr_prdata = CSR_DATA_BITS'(start_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign process    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = out_loc_ff;

   // a skip that has run out hands this byte to the scan
   assign mode_eff   = (mode_ff == MODE_SKIP && skip_ff == '0) ? MODE_SCAN : mode_ff;
   assign recent_eff = (mode_ff == MODE_SKIP) ? 24'd0 : recent_ff;
   assign count_eff  = (mode_ff == MODE_SKIP) ? 2'd0 : count_ff;
   assign window     = {in_byte_ff, recent_eff};
   assign hit        = (count_eff == WINDOW_FULL) && tag_char_ok(window[7:0]) &&
                       tag_char_ok(window[15:8]) && tag_char_ok(window[23:16]) &&
                       (in_byte_ff == CHAR_M);
   assign match      = (window == target_ff);
   assign acc_next   = acc_ff | (SIZE_BITS'(in_byte_ff) << {idx_ff, 3'b000});
   assign hdr_pos    = pos_ff - HDR_BACK;

   // next parse mode
   always_comb begin
      mode_in = mode_ff;
      if (process) begin
         case (mode_eff)
            MODE_SKIP: mode_in = MODE_SKIP;
            MODE_SCAN: begin
               if (hit && match) begin
                  mode_in = MODE_DONE;
               end else if (hit) begin
                  mode_in = MODE_SIZE;
               end else begin
                  mode_in = MODE_SCAN;
               end
            end
            MODE_SIZE: mode_in = (idx_ff == SIZE_LAST) ? MODE_SKIP : MODE_SIZE;
            MODE_DONE: mode_in = MODE_DONE;
            default:   mode_in = MODE_SKIP;
         endcase
         if (in_last_ff) begin
            mode_in = MODE_SKIP;
         end
      end
   end

   // datapath, result and register port
   always_comb begin
      target_in    = target_ff;
      start_in     = start_ff;
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_found_in = out_found_ff;
      out_loc_in   = out_loc_ff;
      pos_in       = pos_ff;
      recent_in    = recent_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      skip_in      = skip_ff;

      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      if (process) begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + OFFSET_BITS'(1);
         end
         case (mode_eff)
            MODE_SKIP: skip_in = skip_ff - OFFSET_BITS'(1);
            MODE_SCAN: begin
               recent_in = {in_byte_ff, recent_eff[23:8]};
               count_in  = (count_eff == WINDOW_FULL) ? count_eff : count_eff + 2'd1;
               if (hit && match) begin
                  out_valid_in = 1'b1;
                  out_found_in = 1'b1;
                  out_loc_in   = LOC_BITS'(hdr_pos);
               end else if (hit) begin
                  acc_in = '0;
                  idx_in = '0;
               end
            end
            MODE_SIZE: begin
               acc_in = acc_next;
               if (idx_ff == SIZE_LAST) begin
                  skip_in = OFFSET_BITS'(acc_next);
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            MODE_DONE: begin
            end
            default: begin
            end
         endcase
         if (in_last_ff) begin
            if (!(mode_eff == MODE_SCAN && hit && match) && mode_ff != MODE_DONE) begin
               out_valid_in = 1'b1;
               out_found_in = 1'b0;
               out_loc_in   = '0;
            end
            pos_in    = '0;
            recent_in = '0;
            count_in  = '0;
            acc_in    = '0;
            idx_in    = '0;
            skip_in   = start_ff;
         end
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_TARGET_TAG:   target_in = csr_pwdata[TAG_BITS-1:0];
            CSR_START_OFFSET: begin
               start_in = OFFSET_BITS'(csr_pwdata);
               if (pos_ff == '0 && mode_ff == MODE_SKIP) begin
                  skip_in = OFFSET_BITS'(csr_pwdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         start_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_SKIP;
         pos_ff       <= '0;
         recent_ff    <= '0;
         count_ff     <= '0;
         acc_ff       <= '0;
         idx_ff       <= '0;
         skip_ff      <= '0;
      end else begin
         target_ff    <= target_in;
         start_ff     <= start_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         recent_ff    <= recent_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         skip_ff      <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      in_last_ff   <= in_last_in;
      out_found_ff <= out_found_in;
      out_loc_ff   <= out_loc_in;
   end

endmodule

`default_nettype wire

FILE: rtl/ctl_checker.sv
// Port-level checks for the chunk tag locator, bound to its top level.
// Depends on ctl_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module ctl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic [ctl_pkg::LOC_BITS-1:0]      rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic                              csr_pready
);
   import ctl_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("not-found result with nonzero location");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && csr_pready) |-> req_tready)
      else $error("input stalled while result slot free");

endmodule

bind chunk_tag_locator ctl_checker u_ctl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_pready (csr_pready)
);

`default_nettype wire
